// ===== src/indexed_sequence_store_core_defines.svh =====
`ifndef INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ISS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iss_pkg.sv =====
`timescale 1ns / 1ps

package iss_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_GET    = 2'd2,
    ACT_SET    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned LengthW = 7;

  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [LengthW-1:0]       length;
    status_e                  status;
  } res_t;

endpackage

// ===== src/indexed_sequence_store_core.sv =====
`timescale 1ns / 1ps
`include "indexed_sequence_store_core_defines.svh"
// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// in       | in_valid_i/in_ready_o | action_i, position_i, run_length_i, item_value_i
// out      | out_valid_o/out_ready_i | read_value_o, length_o, status_o
//
// One transfer in flight. From input transfer to result in the output register: a set or a
// rejected action goes straight to the result; a get waits for the entry RAM read; insert/erase
// shift entries (up to CAPACITY-1 moves), then write the new entry if inserting and update the length.
// Shifts move one entry per cycle through the single write port of the entry RAM.
// Reset clears the length and returns the sequencer to idle; entry RAM contents are not cleared.
// A stalled output holds the sequencer in its result state; input waits until it drains.

module indexed_sequence_store_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [6:0]         position_i,
  input  logic [6:0]         run_length_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         length_o,
  output logic [1:0]         status_o
);

  import iss_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic          res_valid, res_ready;
  res_t          res, out_q;
  logic          out_valid_q;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  iss_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_e'(action_i)),
    .position_i   (position_i),
    .run_length_i (run_length_i),
    .item_value_i (item_value_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  iss_ram #(
    .Width(32),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q.read_value;
  assign length_o     = out_q.length;
  assign status_o     = out_q.status;

  `ISS_ASSERT_NOW(a_value_only_on_done, out_valid_o && read_value_o != '0, status_o == ST_DONE, "read value on failed action")
  `ISS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "second transfer taken while busy")
  `ISS_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid, "result dropped while output full")

endmodule

// ===== src/iss_ram.sv =====
`timescale 1ns / 1ps

module iss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/iss_seq.sv =====
`timescale 1ns / 1ps

module iss_seq #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  iss_pkg::action_e    action_i,
  input  logic [6:0]          position_i,
  input  logic [6:0]          run_length_i,
  input  logic signed [31:0]  item_value_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output iss_pkg::res_t       res_o,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output logic [31:0]         ram_wdata_o,
  output logic                ram_re_o,
  output logic [AW-1:0]       ram_raddr_o,
  input  logic [31:0]         ram_rdata_i
);

  import iss_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_GETW,
    S_FIN,
    S_DONE
  } state_e;

  state_e            state_q;
  action_e           act_q;
  status_e           status_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     run_q;
  logic [AW-1:0]     pos_q;
  logic [AW-1:0]     src_q;
  logic [AW-1:0]     pdst_q;
  logic              pend_q;
  logic signed [31:0] val_q;
  logic signed [31:0] rdval_q;

  logic [XW-1:0] pos_x, run_x, cnt_x, end_x, cnt_m1;
  logic [AW-1:0] pos_a, last_a;
  status_e       chk;
  logic          acc, ok;

  assign pos_x  = XW'(position_i);
  assign run_x  = XW'(run_length_i);
  assign cnt_x  = XW'(cnt_q);
  assign end_x  = pos_x + run_x;
  assign cnt_m1 = cnt_x - XW'(1);
  assign pos_a  = pos_x[AW-1:0];
  assign last_a = cnt_m1[AW-1:0];

  assign acc = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    chk = ST_DONE;
    unique case (action_i)
      ACT_INSERT: begin
        if (pos_x > cnt_x) begin
          chk = ST_RANGE;
        end else if (cnt_x == XW'(CAPACITY)) begin
          chk = ST_FULL;
        end
      end
      ACT_ERASE: begin
        if (pos_x >= cnt_x || run_x == '0 || end_x > cnt_x) begin
          chk = ST_RANGE;
        end
      end
      default: begin
        if (pos_x >= cnt_x) begin
          chk = ST_RANGE;
        end
      end
    endcase
  end

  assign ok = (chk == ST_DONE);

  always_comb begin
    ram_re_o    = 1'b0;
    ram_raddr_o = src_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pdst_q;
    ram_wdata_o = ram_rdata_i;
    if (acc && ok && action_i == ACT_GET) begin
      ram_re_o    = 1'b1;
      ram_raddr_o = pos_a;
    end
    if (acc && ok && action_i == ACT_SET) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = pos_a;
      ram_wdata_o = item_value_i;
    end
    if (state_q == S_SHIFT) begin
      ram_re_o = 1'b1;
    end
    if (pend_q) begin
      ram_we_o = 1'b1;
    end
    if (state_q == S_FIN && act_q == ACT_INSERT) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = pos_q;
      ram_wdata_o = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= (state_q == S_SHIFT);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q    <= action_i;
            pos_q    <= pos_a;
            run_q    <= run_x[CW-1:0];
            val_q    <= item_value_i;
            status_q <= chk;
            rdval_q  <= '0;
            if (!ok) begin
              state_q <= S_DONE;
            end else begin
              unique case (action_i)
                ACT_INSERT: begin
                  src_q   <= last_a;
                  state_q <= (pos_x == cnt_x) ? S_FIN : S_SHIFT;
                end
                ACT_ERASE: begin
                  src_q   <= end_x[AW-1:0];
                  state_q <= (end_x == cnt_x) ? S_FIN : S_SHIFT;
                end
                ACT_GET: state_q <= S_GETW;
                default: state_q <= S_DONE;
              endcase
            end
          end
        end
        S_SHIFT: begin
          if (act_q == ACT_INSERT) begin
            pdst_q <= src_q + AW'(1);
            src_q  <= src_q - AW'(1);
            if (src_q == pos_q) begin
              state_q <= S_DRAIN;
            end
          end else begin
            pdst_q <= src_q - run_q[AW-1:0];
            src_q  <= src_q + AW'(1);
            if (src_q == last_a) begin
              state_q <= S_DRAIN;
            end
          end
        end
        S_DRAIN: state_q <= S_FIN;
        S_GETW: begin
          rdval_q <= ram_rdata_i;
          state_q <= S_DONE;
        end
        S_FIN: begin
          cnt_q   <= (act_q == ACT_INSERT) ? cnt_q + CW'(1) : cnt_q - run_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.read_value  = rdval_q;
  assign res_o.length      = cnt_x[LengthW-1:0];
  assign res_o.status      = status_q;

endmodule
